### sv/gait_event_detector_defines.svh
// assertion macros for the gait event detector
// each macro expects clk and arst_n in scope
`ifndef GAIT_EVENT_DETECTOR_DEFINES_SVH
`define GAIT_EVENT_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold on every rising clock edge out of reset
`define GED_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("gait_event_detector check failed");

// condition must never be seen on a rising clock edge out of reset
`define GED_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("gait_event_detector illegal condition");

`else

`define GED_ASSERT(lbl, prop)
`define GED_NEVER(lbl, cond)

`endif

`endif

### sv/ged_pkg.sv
package ged_pkg;

	// field widths
	localparam int STAMP_W    = 32;
	localparam int LOAD_W     = 16;
	localparam int TIME_W     = 33;
	localparam int DUR_W      = 34;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 144;

	// default window depth
	localparam int WINDOW_DEFAULT = 8;

	// leg phase codes kept in the windows
	localparam logic [1:0] PH_INVALID = 2'd0;
	localparam logic [1:0] PH_SWING   = 2'd1;
	localparam logic [1:0] PH_STANCE  = 2'd2;

	// leading leg codes
	localparam logic [1:0] LEG_INVALID = 2'd0;
	localparam logic [1:0] LEG_RIGHT   = 2'd1;
	localparam logic [1:0] LEG_LEFT    = 2'd2;

	// gait phase codes
	localparam logic [1:0] GAIT_INVALID     = 2'd0;
	localparam logic [1:0] GAIT_DOUBLE      = 2'd1;
	localparam logic [1:0] GAIT_LEFT_SWING  = 2'd2;
	localparam logic [1:0] GAIT_RIGHT_SWING = 2'd3;

	// events detected on one leg for the current sample
	typedef struct packed {
		logic heel_strike;
		logic toe_off;
	} leg_evt_t;

endpackage

### sv/ged_leg_window.sv
module ged_leg_window
	import ged_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     shift_en,
	input  logic     stance,
	output leg_evt_t evt
);

	logic [1:0] win_q [WINDOW];
	logic [1:0] new_ph;

	assign new_ph = stance ? PH_STANCE : PH_SWING;

	// shift window, oldest entry at index 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= PH_INVALID;
			end
		end else if (shift_en) begin
			for (int i = 0; i < WINDOW - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[WINDOW - 1] <= new_ph;
		end
	end

	// edge detect on the window as it stands after this sample is pushed
	always_comb begin
		logic all_swing;
		logic all_stance;
		all_swing  = 1'b1;
		all_stance = 1'b1;
		for (int i = 1; i < WINDOW; i++) begin
			if (win_q[i] != PH_SWING) all_swing = 1'b0;
			if (win_q[i] != PH_STANCE) all_stance = 1'b0;
		end
		evt.heel_strike = all_swing && stance;
		evt.toe_off     = all_stance && !stance;
	end

endmodule

### sv/gait_event_detector.sv
// gait event detector
// slave channel s_*: one request per load sample, tdata holds time stamp,
// right load and left load; a load above zero counts as stance.
// master channel m_*: one result per sample with gait phase, leading leg,
// latest heel strike and toe off times, double and single support
// durations and the ready flag.
// a taken request is held in the input register and worked on there; its
// result is loaded into the result register once that is empty or being
// read. throughput is one sample per cycle while the receiver keeps up, set
// by the single compute stage between the input register and the result
// register.
// when the receiver stalls, the result holds and the input register
// still takes one more request; s_tready falls once both are full.
// reset empties both stages, clears the phase windows to invalid, sets
// all event times and durations to -1 and the leading leg to invalid.
`include "gait_event_detector_defines.svh"

module gait_event_detector
	import ged_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// time_stamp[31:0], right_load[47:32], left_load[63:48]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// gait_phase[1:0], leading_leg[3:2], heel_strike_time[36:4],
	// toe_off_time[69:37], double_support_duration[103:70],
	// single_support_duration[137:104], ready_res[138], zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// input stage
	logic                     v_s1;
	logic [STAMP_W-1:0]       stamp_s1;
	logic signed [LOAD_W-1:0] right_s1;
	logic signed [LOAD_W-1:0] left_s1;
	logic                     adv;

	// state
	logic [1:0]               lead_q;
	logic signed [TIME_W-1:0] r_heel_q, l_heel_q, r_toe_q, l_toe_q;
	logic signed [DUR_W-1:0]  ds_q, ss_q;

	// next state
	logic [1:0]               lead_n, phase_n;
	logic signed [TIME_W-1:0] r_heel_n, l_heel_n, r_toe_n, l_toe_n, t_ext;
	logic signed [TIME_W-1:0] hs_max, to_max;
	logic signed [DUR_W-1:0]  ds_n, ss_n;
	logic                     r_stance, l_stance, ready_n;
	leg_evt_t                 r_evt, l_evt;

	// handshake between the stages
	assign adv      = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			stamp_s1 <= s_tdata[STAMP_W-1:0];
			right_s1 <= s_tdata[STAMP_W+LOAD_W-1:STAMP_W];
			left_s1  <= s_tdata[STAMP_W+2*LOAD_W-1:STAMP_W+LOAD_W];
		end
	end

	// stance classification
	assign r_stance = right_s1 > $signed(LOAD_W'(0));
	assign l_stance = left_s1 > $signed(LOAD_W'(0));

	ged_leg_window #(.WINDOW(WINDOW)) u_right_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv),
		.stance   (r_stance),
		.evt      (r_evt)
	);

	ged_leg_window #(.WINDOW(WINDOW)) u_left_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (adv),
		.stance   (l_stance),
		.evt      (l_evt)
	);

	// event times and leading leg
	always_comb begin
		t_ext    = $signed({1'b0, stamp_s1});
		r_heel_n = r_evt.heel_strike ? t_ext : r_heel_q;
		l_heel_n = l_evt.heel_strike ? t_ext : l_heel_q;
		r_toe_n  = r_evt.toe_off ? t_ext : r_toe_q;
		l_toe_n  = l_evt.toe_off ? t_ext : l_toe_q;
		if (r_evt.heel_strike) begin
			lead_n = LEG_RIGHT;
		end else if (l_evt.heel_strike) begin
			lead_n = LEG_LEFT;
		end else begin
			lead_n = lead_q;
		end
	end

	// support durations, -1 compares as an ordinary number
	always_comb begin
		ds_n = ds_q;
		ss_n = ss_q;
		if (l_toe_n > r_heel_n && lead_n == LEG_RIGHT) begin
			ds_n = DUR_W'(l_toe_n) - DUR_W'(r_heel_n);
		end
		if (r_toe_n > l_heel_n && lead_n == LEG_LEFT) begin
			ds_n = DUR_W'(r_toe_n) - DUR_W'(l_heel_n);
		end
		if (l_heel_n > l_toe_n && lead_n == LEG_LEFT) begin
			ss_n = DUR_W'(l_heel_n) - DUR_W'(l_toe_n);
		end
		if (r_heel_n > r_toe_n && lead_n == LEG_RIGHT) begin
			ss_n = DUR_W'(r_heel_n) - DUR_W'(r_toe_n);
		end
	end

	// gait phase, ready flag and latest event times
	always_comb begin
		if (r_stance && l_stance) begin
			phase_n = GAIT_DOUBLE;
		end else if (r_stance) begin
			phase_n = GAIT_LEFT_SWING;
		end else if (l_stance) begin
			phase_n = GAIT_RIGHT_SWING;
		end else begin
			phase_n = GAIT_INVALID;
		end
		ready_n = !r_heel_n[TIME_W-1] && !r_toe_n[TIME_W-1] &&
			!l_heel_n[TIME_W-1] && !l_toe_n[TIME_W-1] &&
			!ds_n[DUR_W-1] && !ss_n[DUR_W-1] &&
			lead_n != LEG_INVALID && phase_n != GAIT_INVALID;
		hs_max = (r_heel_n > l_heel_n) ? r_heel_n : l_heel_n;
		to_max = (r_toe_n > l_toe_n) ? r_toe_n : l_toe_n;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= LEG_INVALID;
			r_heel_q <= '1;
			l_heel_q <= '1;
			r_toe_q  <= '1;
			l_toe_q  <= '1;
			ds_q     <= '1;
			ss_q     <= '1;
		end else if (adv) begin
			lead_q   <= lead_n;
			r_heel_q <= r_heel_n;
			l_heel_q <= l_heel_n;
			r_toe_q  <= r_toe_n;
			l_toe_q  <= l_toe_n;
			ds_q     <= ds_n;
			ss_q     <= ss_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {5'd0, ready_n, ss_n, ds_n, to_max, hs_max, lead_n, phase_n};
		end
	end

	// checks
	`GED_ASSERT(a_full_when_blocked, !s_tready |-> (v_s1 && m_tvalid))
	`GED_ASSERT(a_lead_sticks, lead_q != LEG_INVALID |=> lead_q != LEG_INVALID)
	`GED_NEVER(a_dur_without_lead, (!ds_q[DUR_W-1] || !ss_q[DUR_W-1]) && lead_q == LEG_INVALID)
	`GED_ASSERT(a_ready_fields, (m_tvalid && m_tdata[138]) |-> (m_tdata[3:2] != LEG_INVALID && m_tdata[1:0] != GAIT_INVALID))

endmodule

### bench/tb_top.sv
module tb_top;
	import ged_pkg::*;

	localparam int WIN        = WINDOW_DEFAULT;
	localparam int IDLE_LIMIT = 4000;
	localparam int RAND_ITEMS = 2000;

	// receiver stall patterns
	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	// one expected result, fields as they leave the block
	typedef struct {
		logic [1:0]        phase;
		logic [1:0]        lead;
		logic [TIME_W-1:0] heel;
		logic [TIME_W-1:0] toe;
		logic [DUR_W-1:0]  dbl;
		logic [DUR_W-1:0]  sgl;
		logic              ready;
	} gait_result_t;

	// gait predictor and queue of results still owed by the block
	class gait_scoreboard #(int DEPTH = 8);
		logic [1:0]   right_win[DEPTH];
		logic [1:0]   left_win[DEPTH];
		logic [1:0]   lead_leg;
		logic [1:0]   phase;
		longint       right_heel;
		longint       left_heel;
		longint       right_toe;
		longint       left_toe;
		longint       dbl_support;
		longint       sgl_support;
		gait_result_t owed[$];
		int           failures;

		function new();
			foreach (right_win[i]) begin
				right_win[i] = PH_INVALID;
				left_win[i]  = PH_INVALID;
			end
			lead_leg    = LEG_INVALID;
			phase       = GAIT_INVALID;
			right_heel  = -1;
			left_heel   = -1;
			right_toe   = -1;
			left_toe    = -1;
			dbl_support = -1;
			sgl_support = -1;
			failures    = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// older entries all equal older_ph and the newest equals newest_ph
		function bit shows_edge(logic [1:0] win[DEPTH], logic [1:0] older_ph,
				logic [1:0] newest_ph);
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (win[i] != older_ph)
					return 1'b0;
			end
			return win[DEPTH-1] == newest_ph;
		endfunction

		// advance the gait state on one accepted request
		function void note_sample(logic [IN_DATA_W-1:0] data);
			longint       stamp;
			logic [1:0]   pr;
			logic [1:0]   pl;
			bit           hs_r;
			bit           hs_l;
			bit           to_r;
			bit           to_l;
			longint       hs_max;
			longint       to_max;
			gait_result_t res;

			stamp = longint'(data[STAMP_W-1:0]);
			pr = ($signed(data[47:32]) > 0) ? PH_STANCE : PH_SWING;
			pl = ($signed(data[63:48]) > 0) ? PH_STANCE : PH_SWING;

			for (int i = 0; i < DEPTH - 1; i++) begin
				right_win[i] = right_win[i+1];
				left_win[i]  = left_win[i+1];
			end
			right_win[DEPTH-1] = pr;
			left_win[DEPTH-1]  = pl;

			hs_r = shows_edge(right_win, PH_SWING, PH_STANCE);
			hs_l = shows_edge(left_win, PH_SWING, PH_STANCE);
			to_r = shows_edge(right_win, PH_STANCE, PH_SWING);
			to_l = shows_edge(left_win, PH_STANCE, PH_SWING);

			// right heel strike wins when both land together
			if (hs_r)
				lead_leg = LEG_RIGHT;
			else if (hs_l)
				lead_leg = LEG_LEFT;

			if (to_r) right_toe = stamp;
			if (to_l) left_toe = stamp;
			if (hs_r) right_heel = stamp;
			if (hs_l) left_heel = stamp;

			// support durations, later rules override earlier ones
			if (left_toe > right_heel && lead_leg == LEG_RIGHT)
				dbl_support = left_toe - right_heel;
			if (right_toe > left_heel && lead_leg == LEG_LEFT)
				dbl_support = right_toe - left_heel;
			if (left_heel > left_toe && lead_leg == LEG_LEFT)
				sgl_support = left_heel - left_toe;
			if (right_heel > right_toe && lead_leg == LEG_RIGHT)
				sgl_support = right_heel - right_toe;

			if (pr == PH_STANCE && pl == PH_STANCE)
				phase = GAIT_DOUBLE;
			else if (pl == PH_SWING && pr == PH_STANCE)
				phase = GAIT_LEFT_SWING;
			else if (pr == PH_SWING && pl == PH_STANCE)
				phase = GAIT_RIGHT_SWING;
			else
				phase = GAIT_INVALID;

			hs_max = (right_heel > left_heel) ? right_heel : left_heel;
			to_max = (right_toe > left_toe) ? right_toe : left_toe;

			res.phase = phase;
			res.lead  = lead_leg;
			res.heel  = hs_max[TIME_W-1:0];
			res.toe   = to_max[TIME_W-1:0];
			res.dbl   = dbl_support[DUR_W-1:0];
			res.sgl   = sgl_support[DUR_W-1:0];
			res.ready = right_heel >= 0 && right_toe >= 0 && left_heel >= 0 &&
				left_toe >= 0 && dbl_support >= 0 && sgl_support >= 0 &&
				lead_leg != LEG_INVALID && phase != GAIT_INVALID;
			owed.push_back(res);
		endfunction

		function void compare_field(string name, logic [DUR_W-1:0] want,
				logic [DUR_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(logic [OUT_DATA_W-1:0] data);
			gait_result_t want;

			if (owed.size() == 0) begin
				$error("result with no request outstanding: %0h", data);
				failures++;
				return;
			end
			want = owed.pop_front();
			compare_field("gait_phase", DUR_W'(want.phase), DUR_W'(data[1:0]));
			compare_field("leading_leg", DUR_W'(want.lead), DUR_W'(data[3:2]));
			compare_field("heel_strike_time", DUR_W'(want.heel), DUR_W'(data[36:4]));
			compare_field("toe_off_time", DUR_W'(want.toe), DUR_W'(data[69:37]));
			compare_field("double_support_duration", want.dbl, data[103:70]);
			compare_field("single_support_duration", want.sgl, data[137:104]);
			compare_field("ready_res", DUR_W'(want.ready), DUR_W'(data[138]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	gait_scoreboard #(WIN) board;
	rx_mode_t              rx_mode = RX_FREE;
	int                    rx_left = 0;
	int                    idle_cycles = 0;

	gait_event_detector #(.WINDOW(WIN)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver ready, switching between stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(10, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_FREE:   m_tready <= 1'b1;
			RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
			default:   m_tready <= ((rx_left % 24) < 6);
		endcase
	end

	// handshake monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				board.note_sample(s_tdata);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL gait_event_detector");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_sample(input logic [31:0] stamp, input logic [15:0] rl,
			input logic [15:0] ll);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {ll, rl, stamp};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// mostly runs long enough to form events, some short broken ones
	function automatic int next_run_length();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(1, WIN - 2);
		return $urandom_range(WIN - 1, 3 * WIN);
	endfunction

	function automatic logic [15:0] make_load(input bit stance);
		int v;
		if (stance) begin
			case ($urandom_range(0, 9))
				0:       v = 1;
				1:       v = 32767;
				default: v = $urandom_range(1, 32767);
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0:       v = 0;
				1:       v = -32768;
				2:       v = -1;
				default: v = -int'($urandom_range(0, 32768));
			endcase
		end
		return v[15:0];
	endfunction

	initial begin : stimulus
		logic [31:0] stamp;
		bit          r_stance;
		bit          l_stance;
		int          r_run;
		int          l_run;
		int          burst_left;

		board    = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// both legs swinging, gait phase invalid
		for (int i = 0; i < WIN - 1; i++)
			send_sample(i * 10, (i % 2) ? 16'h8000 : 16'h0000,
				(i % 2) ? 16'h0000 : 16'hFFFF);
		// heel strike on both legs at once, right leads
		send_sample(32'd100, 16'h7FFF, 16'h0001);
		for (int i = 1; i < WIN - 1; i++)
			send_sample(100 + i * 10, 16'h0001, 16'h7FFF);
		// right toe off, then left toe off gives double support
		send_sample(32'd170, 16'h0000, 16'h7FFF);
		send_sample(32'd180, 16'hFFFF, 16'h0000);
		// left lands again without a heel strike, leading leg holds
		for (int i = 0; i < WIN - 2; i++)
			send_sample(190 + i * 10, 16'h8000, 16'h2AAA);
		// right heel strike at the largest stamp gives single support
		send_sample(32'hFFFF_FFFF, 16'h5555, 16'h1234);
		// stamp going backwards
		send_sample(32'd50, 16'h4000, 16'h7FFF);

		wait_drained();

		stamp      = 32'd1000;
		r_stance   = 1'b0;
		l_stance   = 1'b1;
		r_run      = next_run_length();
		l_run      = $urandom_range(1, 2 * WIN);
		burst_left = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					pause_sender($urandom_range(1, 8));
			end
			burst_left--;
			if (n == RAND_ITEMS / 2)
				wait_drained();

			if (r_run == 0) begin
				r_stance = !r_stance;
				r_run    = next_run_length();
			end
			if (l_run == 0) begin
				l_stance = !l_stance;
				l_run    = next_run_length();
			end
			r_run--;
			l_run--;

			// mostly small forward steps, rare jumps and rewinds
			case ($urandom_range(0, 99))
				0:       stamp = $urandom;
				1:       stamp = stamp - $urandom_range(1, 100);
				default: stamp = stamp + $urandom_range(0, 40);
			endcase
			send_sample(stamp, make_load(r_stance), make_load(l_stance));
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (board.failures == 0 && board.pending() == 0) begin
			$display("PASS gait_event_detector");
		end else begin
			$display("FAIL gait_event_detector");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/ged_pkg.sv
sv/ged_leg_window.sv
sv/gait_event_detector.sv
bench/tb_top.sv
